[hw/rtl/mbp_pkg.sv]
// Package for the MSB-first bit packer.
// Holds the operation codes, sizing constants and the job record passed
// from the front end through the queue to the byte emitter.
package mbp_pkg;

  localparam int WORD_BITS   = 32;
  localparam int BYTE_BITS   = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [2:0]           nbytes;
    logic [31:0]          total;
  } job_t;

endpackage

[hw/rtl/msb_first_bit_packer.sv]
// Channel  | valid      | stall      | payload
// item     | item_valid | item_stall | operation, field_value, field_width
// byte     | byte_valid | byte_stall | out_byte, last_of_run, bits_total
//
// An item is taken by the front end whenever the job queue is not full; the
// emitter sends one byte per cycle while byte_stall is low, so a word-completing
// write gives four bytes on the byte channel and a flush gives one to four.
// The front end can take new items while earlier jobs still wait or are emitted.
// Synchronous reset clears the accumulator, bit count, queue and emitter.
// item_stall rises when the job queue is full; byte_stall holds the output.
module msb_first_bit_packer #(
  parameter int QueueDepth = mbp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        operation,
  input  logic [31:0] field_value,
  input  logic [5:0]  field_width,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic [31:0] bits_total
);

  logic          push;
  mbp_pkg::job_t push_job;
  logic          full;
  logic          pop;
  logic          q_valid;
  mbp_pkg::job_t q_job;

  mbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .operation   (operation),
    .field_value (field_value),
    .field_width (field_width),
    .full        (full),
    .push        (push),
    .push_job    (push_job)
  );

  mbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  mbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .pop         (pop),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .bits_total  (bits_total)
  );

endmodule

[hw/rtl/mbp_front.sv]
// Front end of the bit packer: accepts transactions, updates the pending
// bit accumulator and bit count, and pushes byte jobs into the queue.
// Depends on mbp_pkg.
module mbp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      operation,
  input  logic [31:0]               field_value,
  input  logic [5:0]                field_width,
  input  logic                      full,
  output logic                      push,
  output mbp_pkg::job_t             push_job
);

  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [4:0]  pending;
  logic [4:0]  pending_next;
  logic [31:0] bit_count;
  logic [31:0] bit_count_next;

  logic        accept;
  logic [5:0]  w_sat;
  logic [31:0] mask;
  logic [31:0] masked;
  logic [5:0]  sh;
  logic [63:0] ext;
  logic [63:0] merged;
  logic [5:0]  sum;
  logic [5:0]  round_up;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  always_comb begin
    w_sat    = (field_width > 6'd32) ? 6'd32 : field_width;
    mask     = 32'hffff_ffff >> (6'd32 - w_sat);
    masked   = field_value & mask;
    sh       = 6'(7'd64 - {2'b00, pending} - {1'b0, w_sat});
    ext      = {32'b0, masked} << sh;
    merged   = {acc, 32'b0} | ext;
    sum      = {1'b0, pending} + w_sat;
    round_up = ({1'b0, pending} + 6'd7) >> 3;
  end

  always_comb begin
    acc_next        = acc;
    pending_next    = pending;
    bit_count_next  = bit_count;
    push            = 1'b0;
    push_job.word   = merged[63:32];
    push_job.nbytes = 3'd4;
    push_job.total  = bit_count + {26'b0, w_sat};
    if (accept) begin
      unique case (operation)
        mbp_pkg::OP_WRITE: begin
          if (w_sat != 6'd0) begin
            bit_count_next = bit_count + {26'b0, w_sat};
            if (sum >= 6'd32) begin
              push         = 1'b1;
              acc_next     = merged[31:0];
              pending_next = 5'(sum - 6'd32);
            end else begin
              acc_next     = merged[63:32];
              pending_next = sum[4:0];
            end
          end
        end
        mbp_pkg::OP_FLUSH: begin
          push_job.word   = acc;
          push_job.nbytes = round_up[2:0];
          push_job.total  = bit_count;
          if (pending != 5'd0) begin
            push         = 1'b1;
            acc_next     = 32'b0;
            pending_next = 5'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 32'b0;
      pending   <= 5'd0;
      bit_count <= 32'b0;
    end else begin
      acc       <= acc_next;
      pending   <= pending_next;
      bit_count <= bit_count_next;
    end
  end

endmodule

[hw/rtl/mbp_queue.sv]
// Job queue between the packer front end and the byte emitter.
// Circular buffer of mbp_pkg::job_t records with a fill count.
module mbp_queue #(
  parameter int Depth = mbp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mbp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output mbp_pkg::job_t q_job
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  mbp_pkg::job_t   slots [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(Depth));
  assign q_valid = (count != CW'(0));
  assign q_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(Depth))
    else $error("queue count out of range");

endmodule

[hw/rtl/mbp_back.sv]
// Byte emitter of the bit packer: takes jobs from the queue and sends
// their bytes high byte first through a registered output stage.
// Depends on mbp_pkg.
module mbp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mbp_pkg::job_t q_job,
  output logic          pop,
  output logic          byte_valid,
  input  logic          byte_stall,
  output logic [7:0]    out_byte,
  output logic          last_of_run,
  output logic [31:0]   bits_total
);

  logic        job_active;
  logic [31:0] job_word;
  logic [2:0]  job_left;
  logic [31:0] job_total;

  logic        load_out;
  logic        last_byte;

  assign load_out  = job_active && (!byte_valid || !byte_stall);
  assign last_byte = (job_left == 3'd1);
  assign pop       = q_valid && (!job_active || (load_out && last_byte));

  always_ff @(posedge clk) begin
    if (pop) begin
      job_word  <= q_job.word;
      job_left  <= q_job.nbytes;
      job_total <= q_job.total;
    end else if (load_out) begin
      job_word <= {job_word[23:0], 8'b0};
      job_left <= job_left - 3'd1;
    end
    if (load_out) begin
      out_byte    <= job_word[31:24];
      last_of_run <= last_byte;
      bits_total  <= job_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_active <= 1'b0;
      byte_valid <= 1'b0;
    end else begin
      if (pop) begin
        job_active <= 1'b1;
      end else if (load_out && last_byte) begin
        job_active <= 1'b0;
      end
      if (load_out) begin
        byte_valid <= 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    job_active |-> (job_left != 3'd0 && job_left <= 3'd4))
    else $error("active job with bad byte count");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!job_active || (load_out && last_byte)))
    else $error("job taken while current job unfinished");

  a_last_ends_job: assert property (@(posedge clk) disable iff (rst)
    (load_out && last_byte && !pop) |=> !job_active)
    else $error("job still active after its last byte");

endmodule
